// ===== sv/lmb_pkg.sv =====
package lmb_pkg;

  localparam int unsigned MAX_LINE_DEF = 2048;

  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned RowW     = 14;
  localparam int unsigned CmpW     = 15;
  localparam int unsigned SumW     = 11;
  localparam int unsigned ProdW    = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam int unsigned MinDim   = 3;
  localparam int unsigned WidthMax = (1 << WidthW) - 1;

  localparam logic [WidthW-1:0]  WIDTH_RST  = WidthW'(640);
  localparam logic [HeightW-1:0] HEIGHT_RST = HeightW'(480);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = CfgIdxW'(1);

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } lmb_pos_t;

  typedef struct packed {
    logic     emit;
    lmb_pos_t pos;
  } lmb_tag_t;

endpackage

// ===== sv/lmb_ram.sv =====
module lmb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lmb_decide.sv =====
module lmb_decide import lmb_pkg::*; (
  input  pix_t           win_i [3][3],
  input  lmb_pos_t       pos_i,
  output logic           fg_o
);

  logic [SumW-1:0]  sum3a, sum3b, sum3c, sum3d;
  logic [SumW-1:0]  sum5t, sum5b, sum5l, sum5r, sum8;
  logic [ProdW-1:0] v8, v1, lim3, lim5;

  // floor(s/k) <= v holds exactly when s < k*(v+1)
  always_comb begin
    sum3a = SumW'(win_i[2][1]) + SumW'(win_i[2][2]) + SumW'(win_i[1][2]);
    sum3b = SumW'(win_i[2][1]) + SumW'(win_i[2][0]) + SumW'(win_i[1][0]);
    sum3c = SumW'(win_i[0][1]) + SumW'(win_i[0][2]) + SumW'(win_i[1][2]);
    sum3d = SumW'(win_i[0][1]) + SumW'(win_i[0][0]) + SumW'(win_i[1][0]);
    sum5t = SumW'(win_i[2][2]) + SumW'(win_i[2][1]) + SumW'(win_i[2][0])
          + SumW'(win_i[1][0]) + SumW'(win_i[1][2]);
    sum5b = SumW'(win_i[0][2]) + SumW'(win_i[0][1]) + SumW'(win_i[0][0])
          + SumW'(win_i[1][0]) + SumW'(win_i[1][2]);
    sum5l = SumW'(win_i[0][2]) + SumW'(win_i[0][1]) + SumW'(win_i[1][2])
          + SumW'(win_i[2][2]) + SumW'(win_i[2][1]);
    sum5r = SumW'(win_i[0][0]) + SumW'(win_i[0][1]) + SumW'(win_i[1][0])
          + SumW'(win_i[2][0]) + SumW'(win_i[2][1]);
    sum8  = sum5r + SumW'(win_i[0][2]) + SumW'(win_i[1][2]) + SumW'(win_i[2][2]);

    v8   = ProdW'(win_i[1][1]) << 3;
    v1   = ProdW'(win_i[1][1]) + ProdW'(1);
    lim3 = (v1 << 1) + v1;
    lim5 = (v1 << 2) + v1;

    priority if (pos_i.top) begin
      if (pos_i.left) begin
        fg_o = ProdW'(sum3a) < lim3;
      end else if (pos_i.right) begin
        fg_o = ProdW'(sum3b) < lim3;
      end else begin
        fg_o = ProdW'(sum5t) < lim5;
      end
    end else if (pos_i.bot) begin
      if (pos_i.left) begin
        fg_o = ProdW'(sum3c) < lim3;
      end else if (pos_i.right) begin
        fg_o = ProdW'(sum3d) < lim3;
      end else begin
        fg_o = ProdW'(sum5b) < lim5;
      end
    end else if (pos_i.left) begin
      fg_o = ProdW'(sum5l) < lim5;
    end else if (pos_i.right) begin
      fg_o = ProdW'(sum5r) < lim5;
    end else begin
      fg_o = v8 >= ProdW'(sum8);
    end
  end

endmodule

// ===== sv/lmb_ctrl.sv =====
module lmb_ctrl import lmb_pkg::*; #(
  parameter int unsigned MaxLine = MAX_LINE_DEF,
  localparam int unsigned ColW = $clog2(MaxLine)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  pix_t                pixel_i,
  input  logic                flush_only_i,
  output logic                enter_o,
  output logic [ColW-1:0]     col_o,
  output pix_t                px_o,
  output lmb_tag_t            tag_o
);

  localparam int unsigned MaxWidth = (MaxLine > WidthMax) ? WidthMax : MaxLine;

  logic [WidthW-1:0]  width_q, eff_w;
  logic [HeightW-1:0] height_q, eff_h;

  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [ColW-1:0]   ic0, ic1, oc0;
  logic [RowW-1:0]   ir0, ir1, or0;
  logic [ColW:0]     ic_inc, oc_inc;
  logic [CmpW-1:0]   wx, hx, ic1x, ocx2;
  logic signed [RowW:0] row_diff;
  logic              frame_in, enter, emit;
  lmb_pos_t          pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[WidthW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WidthW'(MinDim)) begin
      eff_w = WidthW'(MinDim);
    end else if (width_q > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < HeightW'(MinDim)) ? HeightW'(MinDim) : height_q;
    wx = CmpW'(eff_w);
    hx = CmpW'(eff_h);
  end

  always_comb begin
    // wrap columns left at or past the width, drop a frame whose row ran out
    ic0 = in_col_q;
    ir0 = in_row_q;
    if (CmpW'(in_col_q) >= wx) begin
      ic0 = '0;
      ir0 = in_row_q + RowW'(1);
    end
    oc0 = out_col_q;
    or0 = out_row_q;
    if (CmpW'(out_col_q) >= wx) begin
      oc0 = '0;
      or0 = out_row_q + RowW'(1);
    end
    if (CmpW'(or0) >= hx) begin
      ic0 = '0;
      ir0 = '0;
      oc0 = '0;
      or0 = '0;
    end

    frame_in = CmpW'(ir0) < hx;
    enter    = !(frame_in && flush_only_i);

    ic_inc = {1'b0, ic0} + (ColW+1)'(1);
    if (CmpW'(ic_inc) >= wx) begin
      ic1 = '0;
      ir1 = ir0 + RowW'(1);
    end else begin
      ic1 = ic_inc[ColW-1:0];
      ir1 = ir0;
    end

    // release a result once input is a row and one pixel ahead of it
    row_diff = $signed({1'b0, ir1}) - $signed({1'b0, or0});
    ic1x = CmpW'(ic1);
    ocx2 = CmpW'(oc0) + CmpW'(2);
    if (row_diff == 1) begin
      emit = ic1x >= ocx2;
    end else if (row_diff == 2) begin
      emit = (wx + ic1x) >= ocx2;
    end else if (row_diff >= 3) begin
      emit = 1'b1;
    end else begin
      emit = 1'b0;
    end
    emit = emit && enter;

    pos.top   = (or0 == '0);
    pos.bot   = (CmpW'(or0) == hx - CmpW'(1));
    pos.left  = (oc0 == '0);
    pos.right = (CmpW'(oc0) == wx - CmpW'(1));
    pos.last  = pos.bot && pos.right;

    oc_inc = {1'b0, oc0} + (ColW+1)'(1);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept_i) begin
      in_col_d  = enter ? ic1 : ic0;
      in_row_d  = enter ? ir1 : ir0;
      out_col_d = oc0;
      out_row_d = or0;
      if (emit) begin
        if (pos.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (CmpW'(oc_inc) >= wx) begin
          out_col_d = '0;
          out_row_d = or0 + RowW'(1);
        end else begin
          out_col_d = oc_inc[ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign enter_o   = enter;
  assign col_o     = ic0;
  assign px_o      = frame_in ? pixel_i : '0;
  assign tag_o.emit = emit;
  assign tag_o.pos  = pos;

endmodule

// ===== sv/local_mean_binarize_3x3.sv =====
// Path: an item that releases a result passes the registered line-memory read
//   (stage 1); the window and decision then load the output register.
// Throughput: 1 item per cycle, set by the single read/write pass on the line memory,
//   while stage 1 is not held by a full, stalled output register.
// Reset: counters, window and output valid clear; width 640, height 480.
//   The line memory is not cleared; no clearing pass is run.
module local_mean_binarize_3x3 import lmb_pkg::*; #(
  parameter int unsigned MaxLine = MAX_LINE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                flush_only_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_foreground_o,
  output logic                last_in_frame_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ColW = $clog2(MaxLine);

  logic            in_xfer, enter, load;
  logic [ColW-1:0] rd_col;
  pix_t            rd_px;
  lmb_tag_t        rd_tag;

  // Stage 1: line memory read in flight
  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_q;
  pix_t            s1_px_q;
  lmb_tag_t        s1_tag_q;
  logic            s1_fire, out_free;

  logic [2*PixW-1:0] rd_data, wr_data, rd_word;
  pix_t              up, lo;

  // Write-back captured for a read of the same column at the same edge
  logic              fwd_q;
  logic [2*PixW-1:0] fwd_data_q;

  pix_t win_q [3][3];
  pix_t win_n [3][3];
  logic fg;

  logic out_valid_q, out_fg_q, out_last_q;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // Hold stage 1 while its result cannot move into the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_tag_q.emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load       = in_xfer && enter;

  lmb_ctrl #(
    .MaxLine (MaxLine)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (in_xfer),
    .pixel_i      (pixel_i),
    .flush_only_i (flush_only_i),
    .enter_o      (enter),
    .col_o        (rd_col),
    .px_o         (rd_px),
    .tag_o        (rd_tag)
  );

  // Each column holds the two rows above the current one: {upper, lower}.
  // The write-back of a column follows its read out of stage 1. Within a frame the
  // next read of that column comes a full row later; only the first item of a
  // new frame rereads column 0 at the edge that writes it back, so forward the
  // write-back data for that case.
  assign rd_word = fwd_q ? fwd_data_q : rd_data;
  assign up      = rd_word[2*PixW-1:PixW];
  assign lo      = rd_word[PixW-1:0];
  assign wr_data = {lo, s1_px_q};

  lmb_ram #(
    .Width (2 * PixW),
    .Depth (MaxLine)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (load),
    .raddr_i (rd_col),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s1_fire) begin
      s1_valid_q <= load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (load) begin
      fwd_q <= s1_fire && (s1_col_q == rd_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_col_q   <= rd_col;
      s1_px_q    <= rd_px;
      s1_tag_q   <= rd_tag;
      fwd_data_q <= wr_data;
    end
  end

  // Shift the window one column left and bring in the new column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_n[k][0] = win_q[k][1];
      win_n[k][1] = win_q[k][2];
    end
    win_n[0][2] = up;
    win_n[1][2] = lo;
    win_n[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_fire) begin
      win_q <= win_n;
    end
  end

  lmb_decide u_decide (
    .win_i (win_n),
    .pos_i (s1_tag_q.pos),
    .fg_o  (fg)
  );

  // Output register: load on a releasing item, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_tag_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_tag_q.emit) begin
      out_fg_q   <= fg;
      out_last_q <= s1_tag_q.pos.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_foreground_o = out_fg_q;
  assign last_in_frame_o = out_last_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lmb_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = CfgIdxW'(3);

  // Cycles to wait after the last result before touching a register: two
  // pipeline stages plus margin for items that release no result.
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum int {
    GREY_ANY,
    GREY_DARK,
    GREY_BW,
    GREY_FLAT
  } grey_style_e;

  typedef struct packed {
    logic fg;
    logic last;
  } bw_pixel_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pix_t                pixel = '0;
  logic                flush_only = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                is_fg;
  logic                last_in_frame;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Traffic shaping: chance in percent that the sender idles or the
  // receiver stalls on a given cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predictor copy of the block: configuration, line stores, window, counters.
  logic [WidthW-1:0]  width_reg;
  logic [HeightW-1:0] height_reg;
  pix_t               upper_line [MAX_LINE_DEF];
  pix_t               lower_line [MAX_LINE_DEF];
  pix_t               win [3][3];
  int unsigned        in_row, in_col, out_row, out_col;
  bit                 frame_wrapped;

  bw_pixel_t binary_pixels_due [$];

  int unsigned transfers = 0;
  int unsigned items_taken = 0;
  int unsigned frames_done = 0;
  int unsigned pixels_checked = 0;
  int unsigned errors = 0;
  int          grey_base = 128;

  local_mean_binarize_3x3 u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pixel_i         (pixel),
    .flush_only_i    (flush_only),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .is_foreground_o (is_fg),
    .last_in_frame_o (last_in_frame),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturate the programmed sizes the same way the block does.
  function automatic int unsigned frame_width();
    if (width_reg < MinDim) return MinDim;
    if (width_reg > MAX_LINE_DEF) return MAX_LINE_DEF;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned frame_height();
    if (height_reg < MinDim) return MinDim;
    return 32'(height_reg);
  endfunction

  // Neighbors that fall outside the frame drop out. Eight neighbors compare
  // exactly; edges and corners compare against the truncated mean.
  function automatic logic center_is_foreground(input int unsigned r, input int unsigned c,
                                                input int unsigned w, input int unsigned h);
    int unsigned nsum, ncount, center;
    int          dr, dc;
    bit          keep;
    nsum = 0;
    ncount = 0;
    center = 32'(win[1][1]);
    for (dr = 0; dr < 3; dr++) begin
      for (dc = 0; dc < 3; dc++) begin
        keep = !(dr == 1 && dc == 1);
        if (dr == 0 && r == 0) keep = 1'b0;
        if (dr == 2 && r == h - 1) keep = 1'b0;
        if (dc == 0 && c == 0) keep = 1'b0;
        if (dc == 2 && c == w - 1) keep = 1'b0;
        if (keep) begin
          nsum += 32'(win[dr][dc]);
          ncount++;
        end
      end
    end
    if (ncount == 8) return (8 * center >= nsum);
    return (center >= nsum / ncount);
  endfunction

  // Advance the predicted stream by one accepted transfer. Return 1 when the
  // transfer releases a binary pixel, placed in bw.
  function automatic logic binarize_item(input pix_t grey, input logic flush,
                                         output bw_pixel_t bw);
    int unsigned w, h, fed, release_at;
    pix_t        above, mid;
    int          k;
    w = frame_width();
    h = frame_height();
    bw = '0;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    // A result row past the height abandons the frame.
    if (out_row >= h) {in_row, in_col, out_row, out_col} = '0;
    if (in_row < h) begin
      if (flush) return 1'b0;
    end else begin
      // Past the last row every item only pushes zeros in.
      grey = '0;
    end
    items_taken++;

    above = upper_line[in_col];
    mid = lower_line[in_col];
    upper_line[in_col] = mid;
    lower_line[in_col] = grey;
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = above;
    win[1][2] = mid;
    win[2][2] = grey;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end

    // Hold the result until the pixel below and to the right is in.
    fed = in_row * w + in_col;
    release_at = out_row * w + out_col + w + 2;
    if (fed < release_at) return 1'b0;

    bw.fg = center_is_foreground(out_row, out_col, w, h);
    bw.last = (out_row == h - 1) && (out_col == w - 1);
    if (bw.last) begin
      {in_row, in_col, out_row, out_col} = '0;
      frame_wrapped = 1'b1;
      frames_done++;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic pix_t pick_grey(input grey_style_e style);
    int v;
    case (style)
      GREY_ANY:  v = $urandom_range(255);
      GREY_DARK: v = $urandom_range(3);
      GREY_BW:   v = $urandom_range(1) ? 255 : 0;
      default:   v = grey_base + int'($urandom_range(4)) - 2;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  // Drive one item at the falling edge after a random idle gap, hold it until
  // the transfer, then predict what it releases.
  task automatic send_item(input pix_t grey, input logic flush);
    int        gap;
    bw_pixel_t bw;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= grey;
    flush_only <= flush;
    do @(posedge clk); while (in_stall !== 1'b0);
    transfers++;
    if (binarize_item(grey, flush, bw)) binary_pixels_due.push_back(bw);
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipe go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (binary_pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_WIDTH) width_reg = data[WidthW-1:0];
    else if (idx == CFG_HEIGHT) height_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Feed items until the predicted frame closes: pixels with a few stray
  // flushes while rows remain, then a mix of flushes and dropped pixels.
  task automatic stream_frame(input grey_style_e style, input int noise_pct);
    logic in_frame, flush;
    frame_wrapped = 1'b0;
    while (!frame_wrapped) begin
      in_frame = (in_row + ((in_col >= frame_width()) ? 1 : 0)) < frame_height();
      if (in_frame) flush = ($urandom_range(99) < noise_pct);
      else flush = 1'($urandom_range(1));
      send_item(pick_grey(style), flush);
    end
  endtask

  // Hand-built 3x3 frames: an interior that meets its mean exactly, bright
  // corners, dim edges, then a frame where truncating the mean flips the
  // verdict. Exercise an ignored flush, dropped pixels and plain flushes.
  task automatic test_directed();
    pix_t grid [18];
    int   k;
    grid = '{255, 1, 255, 1, 128, 1, 255, 1, 255,
             0, 1, 1, 1, 0, 1, 1, 1, 0};
    // Width with a bit above the register, height below the floor, and a
    // write to an unused index.
    write_reg(CFG_WIDTH, 13'h1003);
    write_reg(CFG_HEIGHT, '0);
    write_reg(CFG_SPARE, 13'h1FFF);
    for (k = 0; k < 18; k++) begin
      if (k == 4) send_item(8'hFF, 1'b1);
      send_item(grid[k], 1'b0);
      if (k == 8) repeat (4) send_item(8'hA5, 1'b0);
      if (k == 17) repeat (4) send_item(8'h00, 1'b1);
    end
    settle();
  endtask

  // Start a frame, pause with the pipe drained, change one register, finish.
  task automatic interrupt_frame(input int unsigned w, input int unsigned h,
                                 input int unsigned n, input logic [CfgIdxW-1:0] idx,
                                 input logic [CfgDataW-1:0] data);
    write_reg(CFG_WIDTH, CfgDataW'(w));
    write_reg(CFG_HEIGHT, CfgDataW'(h));
    repeat (n) send_item(pick_grey(GREY_ANY), 1'b0);
    settle();
    write_reg(idx, data);
    stream_frame(GREY_ANY, 5);
    settle();
  endtask

  task automatic test_mid_frame_regs();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Tallest frame cut short: shrinking the height abandons it.
    interrupt_frame(3, 13'h1FFF, 15, CFG_HEIGHT, 13'd3);
    // Narrow the line while rows are in flight.
    interrupt_frame(9, 5, 22, CFG_WIDTH, 13'd4);
    // Grow the height, then the width, part way through.
    interrupt_frame(5, 3, 8, CFG_HEIGHT, 13'd6);
    interrupt_frame(5, 4, 8, CFG_WIDTH, 13'd7);
  endtask

  // Random frames over four traffic mixes; sizes mostly small, some wider,
  // some out of range so the saturation shows.
  task automatic test_random_frames();
    int                  phase, pick;
    int unsigned         goal;
    logic [CfgDataW-1:0] wdata, hdata;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      goal = items_taken + 200;
      while (items_taken < goal) begin
        pick = $urandom_range(99);
        if (pick < 10) wdata = CfgDataW'($urandom_range(2));
        else if (pick < 20) wdata = CfgDataW'(32'h1000 | $urandom_range(8, 3));
        else if (pick < 35) wdata = CfgDataW'($urandom_range(40, 9));
        else wdata = CfgDataW'($urandom_range(8, 3));
        if ($urandom_range(9) == 0) hdata = CfgDataW'($urandom_range(2));
        else hdata = CfgDataW'($urandom_range(6, 3));
        grey_base = $urandom_range(255);
        write_reg(CFG_WIDTH, wdata);
        write_reg(CFG_HEIGHT, hdata);
        stream_frame(grey_style_e'($urandom_range(3)), 5);
        settle();
      end
    end
  endtask

  // Receiver: stall at random per the current mix.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check every result transfer against the oldest predicted binary pixel.
  always @(posedge clk) begin
    bw_pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (binary_pixels_due.size() == 0) begin
        $error("result with none due: is_foreground=%0b last_in_frame=%0b",
               is_fg, last_in_frame);
        errors++;
      end else begin
        want = binary_pixels_due.pop_front();
        pixels_checked++;
        if (is_fg !== want.fg) begin
          $error("is_foreground mismatch: expected %0b, got %0b", want.fg, is_fg);
          errors++;
        end
        if (last_in_frame !== want.last) begin
          $error("last_in_frame mismatch: expected %0b, got %0b", want.last, last_in_frame);
          errors++;
        end
      end
    end
  end

  initial begin
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    for (int i = 0; i < MAX_LINE_DEF; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    {in_row, in_col, out_row, out_col} = '0;

    // Hold reset, then release it between edges.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_mid_frame_regs();
    test_random_frames();

    // Give stragglers a bounded time to arrive.
    @(negedge clk);
    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && binary_pixels_due.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (binary_pixels_due.size() != 0) begin
      $error("%0d binary pixels never arrived", binary_pixels_due.size());
      errors++;
    end

    $display("Run covered %0d transfers (%0d used), %0d binary pixels checked, %0d frames.",
             transfers, items_taken, pixels_checked, frames_done);
    $display("Lines from 3 to 40 wide, heights up to 8191, mid-frame register changes.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    #(64'd10_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lmb_pkg.sv
sv/lmb_ram.sv
sv/lmb_decide.sv
sv/lmb_ctrl.sv
sv/local_mean_binarize_3x3.sv
tb/sv/tb.sv
